// ----- design/rdv_pkg.sv -----
`default_nettype none
package rdv_pkg;

	typedef enum logic {
		KIND_UNSIGNED = 1'b0,
		KIND_SIGNED   = 1'b1
	} kind_t;

	typedef struct packed {
		logic n_neg;
		logic d_neg;
		logic dz;
	} rdv_ctl_t;

endpackage
`default_nettype wire

// ----- design/rdv_if.sv -----
`default_nettype none
interface rdv_req_if
	import rdv_pkg::*;
#(
	parameter int DATA_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	kind_t                 kind;
	logic [DATA_WIDTH-1:0] dividend;
	logic [DATA_WIDTH-1:0] divisor;

	modport source (output valid, kind, dividend, divisor, input ready);
	modport sink   (input valid, kind, dividend, divisor, output ready);
endinterface

interface rdv_rsp_if #(
	parameter int DATA_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] quotient;
	logic [DATA_WIDTH-1:0] remainder;
	logic                  div_by_zero;

	modport source (output valid, quotient, remainder, div_by_zero, input ready);
	modport sink   (input valid, quotient, remainder, div_by_zero, output ready);
endinterface
`default_nettype wire

// ----- design/rdv_step.sv -----
`default_nettype none
module rdv_step #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic [DATA_WIDTH-1:0] r_in,
	input  wire logic                  n_bit,
	input  wire logic [DATA_WIDTH-1:0] d,
	output logic      [DATA_WIDTH-1:0] r_out,
	output logic                       q_bit
);
	logic [DATA_WIDTH:0] t;
	logic [DATA_WIDTH:0] diff;

	always_comb begin
		t     = {r_in, n_bit};
		diff  = t - {1'b0, d};
		q_bit = (t >= {1'b0, d});
		r_out = q_bit ? diff[DATA_WIDTH-1:0] : t[DATA_WIDTH-1:0];
	end
endmodule
`default_nettype wire

// ----- design/restoring_integer_divider.sv -----
`default_nettype none
// Stages from an accepted request beat to its response beat
// (sign stage, one stage per quotient bit, sign restore stage).
// Throughput: one division per cycle; the whole pipeline holds while a response waits.
// Reset: arst_n clears every stage valid bit at once; data registers are not reset.
module restoring_integer_divider
	import rdv_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rdv_req_if.sink    req,
	rdv_rsp_if.source  rsp
);
	localparam int W = DATA_WIDTH;

	logic en;

	logic          valid_s1;
	rdv_ctl_t      ctl_s1;
	kind_t         kind_s1;
	logic [W-1:0]  n_s1;
	logic [W-1:0]  d_s1;

	logic          valid_s2 [W];
	rdv_ctl_t      ctl_s2   [W];
	kind_t         kind_s2  [W];
	logic [W-1:0]  n_s2     [W];
	logic [W-1:0]  d_s2     [W];
	logic [W-1:0]  q_s2     [W];
	logic [W-1:0]  r_s2     [W];

	logic          valid_s3;
	logic [W-1:0]  q_s3;
	logic [W-1:0]  r_s3;
	logic          dz_s3;

	logic          n_neg;
	logic          d_neg;

	assign en        = !valid_s3 || rsp.ready;
	assign req.ready = en;

	assign n_neg = (req.kind == KIND_SIGNED) && req.dividend[W-1];
	assign d_neg = (req.kind == KIND_SIGNED) && req.divisor[W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1      <= req.kind;
			ctl_s1.n_neg <= n_neg;
			ctl_s1.d_neg <= d_neg;
			ctl_s1.dz    <= (req.divisor == '0);
			n_s1         <= n_neg ? (~req.dividend + W'(1)) : req.dividend;
			d_s1         <= d_neg ? (~req.divisor + W'(1)) : req.divisor;
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_step
		logic          valid_in;
		rdv_ctl_t      ctl_in;
		kind_t         kind_in;
		logic [W-1:0]  n_in;
		logic [W-1:0]  d_in;
		logic [W-1:0]  q_in;
		logic [W-1:0]  r_in;
		logic [W-1:0]  r_nx;
		logic          q_bit;

		if (k == 0) begin : g_first
			assign valid_in = valid_s1;
			assign ctl_in   = ctl_s1;
			assign kind_in  = kind_s1;
			assign n_in     = n_s1;
			assign d_in     = d_s1;
			assign q_in     = '0;
			assign r_in     = '0;
		end else begin : g_next
			assign valid_in = valid_s2[k-1];
			assign ctl_in   = ctl_s2[k-1];
			assign kind_in  = kind_s2[k-1];
			assign n_in     = n_s2[k-1];
			assign d_in     = d_s2[k-1];
			assign q_in     = q_s2[k-1];
			assign r_in     = r_s2[k-1];
		end

		rdv_step #(
			.DATA_WIDTH(W)
		) u_step (
			.r_in  (r_in),
			.n_bit (n_in[W-1-k]),
			.d     (d_in),
			.r_out (r_nx),
			.q_bit (q_bit)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s2[k] <= 1'b0;
			end else if (en) begin
				valid_s2[k] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_s2[k]  <= ctl_in;
				kind_s2[k] <= kind_in;
				n_s2[k]    <= n_in;
				d_s2[k]    <= d_in;
				r_s2[k]    <= r_nx;
				q_s2[k]    <= q_in | (W'(q_bit) << (W-1-k));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2[W-1];
		end
	end

	// restore signs: quotient when signs differ, remainder after the dividend; register the divide-by-zero flag
	always_ff @(posedge clk) begin
		if (en) begin
			q_s3  <= (ctl_s2[W-1].n_neg ^ ctl_s2[W-1].d_neg)
				? (~q_s2[W-1] + W'(1)) : q_s2[W-1];
			r_s3  <= ctl_s2[W-1].n_neg ? (~r_s2[W-1] + W'(1)) : r_s2[W-1];
			dz_s3 <= ctl_s2[W-1].dz && (kind_s2[W-1] == KIND_SIGNED
				|| kind_s2[W-1] == KIND_UNSIGNED);
		end
	end

	assign rsp.valid       = valid_s3;
	assign rsp.quotient    = q_s3;
	assign rsp.remainder   = r_s3;
	assign rsp.div_by_zero = dz_s3;
endmodule
`default_nettype wire
